FILE: rtl/core/mnsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsp_pkg: shared types for the MIDI note span pairer
// Event and span beat layouts, event kind codes and field widths.
// ----------------------------------------------------------------------------
package mnsp_pkg;

  localparam int unsigned NOTE_BITS = 7;
  localparam int unsigned VEL_BITS  = 7;
  localparam int unsigned TICK_BITS = 32;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OFF   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [NOTE_BITS-1:0] note_number;
    logic [VEL_BITS-1:0]  key_velocity;
    logic [TICK_BITS-1:0] event_tick;
  } event_t;

  typedef struct packed {
    logic [NOTE_BITS-1:0] span_note;
    logic [VEL_BITS-1:0]  span_velocity;
    logic [TICK_BITS-1:0] span_start;
    logic [TICK_BITS-1:0] span_end;
  } span_t;

  // Layout of one entry of the open-note store
  typedef struct packed {
    logic [VEL_BITS-1:0]  velocity;
    logic [TICK_BITS-1:0] onset_tick;
  } entry_t;

endpackage

FILE: rtl/core/mnsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mnsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/midi_note_span_pairer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_span_pairer_core: pairs note-on and note-off events into spans
// Keeps a per-note open flag in flops and the start tick and velocity in a
// RAM; a release that finds its note open emits one span beat.
// ----------------------------------------------------------------------------
//
//  channel   ports                         direction  handshake
//  -------   ----------------------------  ---------  ------------------------
//  event     start, busy, event_i          in         start && !busy
//  span      span_valid_o, span_o          out        strobe, one cycle
//
//  One event is accepted every cycle; busy stays low.
//  A span leaves in the cycle after the releasing event, set by the registered
//  read port of the entry RAM. A note-on writes its entry at acceptance, so
//  a release on the same note in the next cycle reads the new data.
//  Reset clears all open flags at once; no clearing pass is needed.
//  The receiver cannot stall: each span is on the ports for one cycle only.
//
module midi_note_span_pairer_core #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mnsp_pkg::event_t event_i,
  output logic            span_valid_o,
  output mnsp_pkg::span_t span_o
);

  localparam int unsigned NoteAw    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int unsigned EntryBits = $bits(mnsp_pkg::entry_t);
  localparam logic [mnsp_pkg::NOTE_BITS:0] NoteLimit = (mnsp_pkg::NOTE_BITS + 1)'(NOTE_COUNT);

  logic                  accept;
  logic                  in_range;
  logic                  is_open;
  logic                  is_release;
  logic                  hit;
  logic                  open_wr;
  logic [NoteAw-1:0]     idx;

  logic [NOTE_COUNT-1:0] open_flag_q, open_flag_d;
  logic                  emit_q;
  logic [mnsp_pkg::NOTE_BITS-1:0] note_q;
  logic [mnsp_pkg::TICK_BITS-1:0] end_q;

  mnsp_pkg::entry_t      wentry;
  mnsp_pkg::entry_t      rentry;
  logic [EntryBits-1:0]  rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_range   = {1'b0, event_i.note_number} < NoteLimit;
  assign idx        = event_i.note_number[NoteAw-1:0];
  assign is_open    = (event_i.kind == mnsp_pkg::KIND_ON) && (event_i.key_velocity != '0);
  assign is_release = (event_i.kind == mnsp_pkg::KIND_OFF) ||
                      ((event_i.kind == mnsp_pkg::KIND_ON) && (event_i.key_velocity == '0));

  assign open_wr = accept && in_range && is_open;
  assign hit     = accept && in_range && is_release && open_flag_q[idx];

  always_comb begin
    open_flag_d = open_flag_q;
    if (open_wr) begin
      open_flag_d[idx] = 1'b1;
    end else if (hit) begin
      open_flag_d[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_flag_q <= '0;
      emit_q      <= 1'b0;
    end else begin
      open_flag_q <= open_flag_d;
      emit_q      <= hit;
    end
  end

  // Hold the releasing event's note and tick alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (hit) begin
      note_q <= event_i.note_number;
      end_q  <= event_i.event_tick;
    end
  end

  assign wentry.velocity   = event_i.key_velocity;
  assign wentry.onset_tick = event_i.event_tick;

  mnsp_ram #(
    .WIDTH (EntryBits),
    .DEPTH (NOTE_COUNT),
    .AW    (NoteAw)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (open_wr),
    .waddr_i (idx),
    .wdata_i (wentry),
    .re_i    (hit),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  assign rentry = rdata;

  assign span_valid_o          = emit_q;
  assign span_o.span_note      = note_q;
  assign span_o.span_velocity  = rentry.velocity;
  assign span_o.span_start     = rentry.onset_tick;
  assign span_o.span_end       = end_q;

  // A span only follows an accepted event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o |-> $past(accept))
    else $error("span without a releasing event");

  // An opened note is marked open in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_wr |=> open_flag_q[$past(idx)])
    else $error("note-on did not open its entry");

  // The note of an emitted span is closed while the span is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o |-> !open_flag_q[note_q[NoteAw-1:0]])
    else $error("span emitted but entry still open");

  // No open and close of one entry in the same beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(open_wr && hit))
    else $error("entry written and read by one event");

endmodule
